/* hw/rtl/scc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_pkg
// shared word types and codes of the strongly connected component orderer
// ---------------------------------------------------------------------------
package scc_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    localparam logic REPLY_RUN  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    localparam logic [1:0] FLAG_SEEN = 2'b01;
    localparam logic [1:0] FLAG_ON   = 2'b10;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] from_node;
        logic [9:0] to_node;
        logic [9:0] position;
    } t_in;

    typedef struct packed {
        logic        reply_kind;
        logic [10:0] block_count;
        logic [1:0]  status;
        logic [9:0]  ordered_node;
        logic [9:0]  block_index;
        logic [10:0] block_size;
    } t_out;

endpackage

/* hw/rtl/scc_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scc_ram
// simple dual port synchronous ram, one write and one registered read port
// ---------------------------------------------------------------------------
module scc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/strongly_connected_components_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strongly_connected_components_top
// tarjan depth-first search that orders a loaded graph into components
// ---------------------------------------------------------------------------
// usage
//   command channel: a word is taken at a clock edge with start high and busy
//   low. opcode load stores one edge (sources in non-decreasing order), run
//   orders the graph, read returns the node at an order position.
//   result channel: o_res_valid marks a result word for exactly one cycle;
//   the receiver cannot hold it off, so it must take every word it sees.
//   config channel: i_cfg_data is the node count, taken while idle
//   (o_cfg_ready is low while busy).
// operations
//   load: no result; the block stays idle, so the next word may follow at once
//   read: three dependent memory reads, through states rd_a and rd_b; the
//   result word is registered as rd_b ends
//   run: a row fix-up pass over the live nodes, then the depth-first search
//   of node pushes, edge walks, node closes and frame returns, each step
//   waiting on the registered read of the node and stack memories; the
//   summary word follows, then a sweep over the whole row table clears it
//   before busy drops
// reset
//   busy stays high after reset while the row table is swept to zero;
//   config writes are still refused until then
// ---------------------------------------------------------------------------
module strongly_connected_components_top
    import scc_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_in,
    output logic        o_res_valid,
    output t_out        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    // one suspended call frame: node, next edge, row end, lowlink, stack slot
    typedef struct packed {
        logic [NW-1:0]  node;
        logic [ECW-1:0] edge_ptr;
        logic [ECW-1:0] row_last;
        logic [NW-1:0]  low;
        logic [NW-1:0]  pos;
    } t_frame;

    localparam int FW = $bits(t_frame);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_FIX, S_OUTER, S_OCHK, S_EDGE, S_TGT, S_CHK,
        S_POP, S_CL_RD, S_CL_WR, S_RET, S_RES, S_DONE, S_RD_A, S_RD_B
    } t_state;

    // control and job state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_live, n_live;
    logic [ECW-1:0] r_edge_cnt, n_edge_cnt;
    logic [NW-1:0]  r_prev_src, n_prev_src;
    logic [1:0]     r_sticky, n_sticky;
    logic [CW-1:0]  r_blocks_found, n_blocks_found;
    logic [CW-1:0]  r_order_cnt, n_order_cnt;
    // search working registers, top frame held in registers
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_sp, n_sp;
    logic [CW-1:0]  r_fp, n_fp;
    logic [CW-1:0]  r_ord, n_ord;
    logic [CW-1:0]  r_blk, n_blk;
    logic [NW-1:0]  r_v, n_v;
    logic [ECW-1:0] r_e, n_e;
    logic [ECW-1:0] r_re, n_re;
    logic [NW-1:0]  r_low, n_low;
    logic [NW-1:0]  r_pos, n_pos;
    logic [NW-1:0]  r_w, n_w;
    logic [ECW-1:0] r_fixprev, n_fixprev;
    // read item
    logic           r_hit, n_hit;
    logic [NW-1:0]  r_x, n_x;
    // result word
    logic           r_res_valid, n_res_valid;
    t_out           r_res, n_res;
    t_out           res_out;

    // memory ports
    logic           edge_we;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [NW-1:0]  edge_wdata, edge_rd;
    logic           rend_we;
    logic [NW-1:0]  rend_waddr, rend_raddr;
    logic [ECW-1:0] rend_wdata, rend_rd;
    logic           rbeg_we;
    logic [NW-1:0]  rbeg_waddr;
    logic [ECW-1:0] rbeg_wdata, rbeg_rd;
    logic           frm_we;
    logic [NW-1:0]  frm_waddr, frm_raddr;
    t_frame         frm_wdata, frm_rd;
    logic           comp_we;
    logic [NW-1:0]  comp_waddr, comp_raddr, comp_wdata, comp_rd;
    logic           spos_we;
    logic [NW-1:0]  spos_waddr, spos_wdata, spos_rd;
    logic           flg_we;
    logic [NW-1:0]  flg_waddr;
    logic [1:0]     flg_wdata, flg_rd;
    logic           omap_we;
    logic [NW-1:0]  omap_waddr, omap_raddr, omap_wdata, omap_rd;
    logic           nblk_we;
    logic [NW-1:0]  nblk_waddr, nblk_raddr, nblk_wdata, nblk_rd;
    logic           bsz_we;
    logic [NW-1:0]  bsz_waddr, bsz_raddr;
    logic [CW-1:0]  bsz_wdata, bsz_rd;
    logic [NW-1:0]  node_raddr;

    logic           accept;
    logic [ECW-1:0] fix_val;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = res_out;

    // node indexed reads come from the edge word while testing a target
    assign node_raddr = (r_state == S_TGT) ? edge_rd : NW'(r_i);
    assign edge_raddr = EW'(r_e);
    assign rend_raddr = node_raddr;
    assign frm_raddr  = NW'(r_fp - CW'(2));
    assign comp_raddr = NW'(r_sp - CW'(1));
    assign omap_raddr = NW'(i_in.position);
    assign nblk_raddr = omap_rd;
    assign bsz_raddr  = nblk_rd;

    // row end fix-up: empty rows inherit the end of the row before, capped at the edge count
    always_comb begin
        fix_val = rend_rd;
        if (fix_val < r_fixprev) begin
            fix_val = r_fixprev;
        end
        if (fix_val > r_edge_cnt) begin
            fix_val = r_edge_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_live         = r_live;
        n_edge_cnt     = r_edge_cnt;
        n_prev_src     = r_prev_src;
        n_sticky       = r_sticky;
        n_blocks_found = r_blocks_found;
        n_order_cnt    = r_order_cnt;
        n_i            = r_i;
        n_sp           = r_sp;
        n_fp           = r_fp;
        n_ord          = r_ord;
        n_blk          = r_blk;
        n_v            = r_v;
        n_e            = r_e;
        n_re           = r_re;
        n_low          = r_low;
        n_pos          = r_pos;
        n_w            = r_w;
        n_fixprev      = r_fixprev;
        n_hit          = r_hit;
        n_x            = r_x;
        n_res_valid    = 1'b0;
        n_res          = r_res;

        edge_we    = 1'b0;
        edge_waddr = EW'(r_edge_cnt);
        edge_wdata = NW'(i_in.to_node);
        rend_we    = 1'b0;
        rend_waddr = NW'(i_in.from_node);
        rend_wdata = r_edge_cnt + ECW'(1);
        rbeg_we    = 1'b0;
        rbeg_waddr = NW'(r_i - CW'(1));
        rbeg_wdata = r_fixprev;
        frm_we     = 1'b0;
        frm_waddr  = NW'(r_fp - CW'(1));
        frm_wdata  = '{node: r_v, edge_ptr: r_e + ECW'(1), row_last: r_re,
                       low: r_low, pos: r_pos};
        comp_we    = 1'b0;
        comp_waddr = NW'(r_sp);
        comp_wdata = NW'(r_i);
        spos_we    = 1'b0;
        spos_waddr = NW'(r_i);
        spos_wdata = NW'(r_sp);
        flg_we     = 1'b0;
        flg_waddr  = NW'(r_i);
        flg_wdata  = FLAG_SEEN | FLAG_ON;
        omap_we    = 1'b0;
        omap_waddr = NW'(r_ord);
        omap_wdata = comp_rd;
        nblk_we    = 1'b0;
        nblk_waddr = comp_rd;
        nblk_wdata = NW'(r_blk);
        bsz_we     = 1'b0;
        bsz_waddr  = NW'(r_blk);
        bsz_wdata  = r_sp - CW'(r_pos);

        if (i_cfg_valid && o_cfg_ready) begin
            if (32'(i_cfg_data) > MAX_NODES) begin
                n_live = CW'(MAX_NODES);
            end else begin
                n_live = CW'(i_cfg_data);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.opcode)
                        OP_LOAD: begin
                            if (i_in.from_node >= r_live || i_in.to_node >= r_live) begin
                                if (r_sticky == ST_OK) n_sticky = ST_RANGE;
                            end else if (i_in.from_node < r_prev_src) begin
                                if (r_sticky == ST_OK) n_sticky = ST_ORDER;
                            end else if (r_edge_cnt >= ECW'(MAX_EDGES)) begin
                                if (r_sticky == ST_OK) n_sticky = ST_FULL;
                            end else begin
                                edge_we    = 1'b1;
                                rend_we    = 1'b1;
                                n_edge_cnt = r_edge_cnt + ECW'(1);
                                n_prev_src = NW'(i_in.from_node);
                            end
                        end
                        OP_RUN: begin
                            n_i       = '0;
                            n_fixprev = '0;
                            n_state   = S_FIX;
                        end
                        OP_READ: begin
                            n_hit   = (i_in.position < r_order_cnt);
                            n_state = S_RD_A;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                rend_we    = 1'b1;
                rend_waddr = NW'(r_i);
                rend_wdata = '0;
                if (r_i == CW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_FIX: begin
                // read row i while writing back the fixed row i-1
                if (r_i != '0) begin
                    rend_we    = 1'b1;
                    rend_waddr = NW'(r_i - CW'(1));
                    rend_wdata = fix_val;
                    rbeg_we    = 1'b1;
                    flg_we     = 1'b1;
                    flg_waddr  = NW'(r_i - CW'(1));
                    flg_wdata  = '0;
                    n_fixprev  = fix_val;
                end
                if (r_i == r_live) begin
                    n_i     = '0;
                    n_sp    = '0;
                    n_fp    = '0;
                    n_ord   = '0;
                    n_blk   = '0;
                    n_state = S_OUTER;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_OUTER: begin
                n_state = (r_i == r_live) ? S_DONE : S_OCHK;
            end
            S_OCHK: begin
                if ((flg_rd & FLAG_SEEN) != '0) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    comp_we = 1'b1;
                    spos_we = 1'b1;
                    flg_we  = 1'b1;
                    n_v     = NW'(r_i);
                    n_e     = rbeg_rd;
                    n_re    = rend_rd;
                    n_low   = NW'(r_sp);
                    n_pos   = NW'(r_sp);
                    n_sp    = r_sp + CW'(1);
                    n_fp    = CW'(1);
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_state = (r_e < r_re) ? S_TGT : S_POP;
            end
            S_TGT: begin
                n_w = edge_rd;
                if (edge_rd >= r_live) begin
                    n_e     = r_e + ECW'(1);
                    n_state = S_EDGE;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_EDGE;
                if ((flg_rd & FLAG_ON) != '0) begin
                    n_e = r_e + ECW'(1);
                    if (spos_rd < r_low) begin
                        n_low = spos_rd;
                    end
                end else if ((flg_rd & FLAG_SEEN) == '0) begin
                    // suspend the current frame, descend into the target
                    frm_we     = 1'b1;
                    comp_we    = 1'b1;
                    comp_wdata = r_w;
                    spos_we    = 1'b1;
                    spos_waddr = r_w;
                    flg_we     = 1'b1;
                    flg_waddr  = r_w;
                    n_v        = r_w;
                    n_e        = rbeg_rd;
                    n_re       = rend_rd;
                    n_low      = NW'(r_sp);
                    n_pos      = NW'(r_sp);
                    n_sp       = r_sp + CW'(1);
                    n_fp       = r_fp + CW'(1);
                end else begin
                    n_e = r_e + ECW'(1);
                end
            end
            S_POP: begin
                if (r_low >= r_pos) begin
                    bsz_we  = 1'b1;
                    n_state = S_CL_RD;
                end else begin
                    n_state = S_RET;
                end
            end
            S_CL_RD: begin
                n_sp    = r_sp - CW'(1);
                n_state = S_CL_WR;
            end
            S_CL_WR: begin
                omap_we   = 1'b1;
                nblk_we   = 1'b1;
                flg_we    = 1'b1;
                flg_waddr = comp_rd;
                flg_wdata = FLAG_SEEN;
                n_ord     = r_ord + CW'(1);
                if (comp_rd != r_v && r_sp != '0) begin
                    n_state = S_CL_RD;
                end else begin
                    n_blk   = r_blk + CW'(1);
                    n_state = S_RET;
                end
            end
            S_RET: begin
                n_fp = r_fp - CW'(1);
                if (r_fp == CW'(1)) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_OUTER;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                n_v     = frm_rd.node;
                n_e     = frm_rd.edge_ptr;
                n_re    = frm_rd.row_last;
                n_pos   = frm_rd.pos;
                n_low   = (r_low < frm_rd.low) ? r_low : frm_rd.low;
                n_state = S_EDGE;
            end
            S_DONE: begin
                n_blocks_found        = r_blk;
                n_order_cnt           = r_ord;
                n_res_valid           = 1'b1;
                n_res                 = '0;
                n_res.reply_kind      = REPLY_RUN;
                n_res.block_count     = 11'(r_blk);
                n_res.status          = r_sticky;
                n_sticky              = ST_OK;
                n_edge_cnt            = '0;
                n_prev_src            = '0;
                n_i                   = '0;
                n_state               = S_CLR;
            end
            S_RD_A: begin
                n_x     = omap_rd;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_state          = S_IDLE;
                n_res_valid      = 1'b1;
                n_res            = '0;
                n_res.reply_kind = REPLY_READ;
                n_res.block_count = 11'(r_blocks_found);
                n_res.status     = r_sticky;
                if (r_hit) begin
                    n_res.ordered_node = 10'(r_x);
                    n_res.block_index  = 10'(nblk_rd);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // block size is read at the registered block index and joins the result word here
    always_comb begin
        res_out = r_res;
        if (r_res.reply_kind == REPLY_READ && r_hit) begin
            res_out.block_size = 11'(bsz_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_live         <= CW'(1);
            r_edge_cnt     <= '0;
            r_prev_src     <= '0;
            r_sticky       <= ST_OK;
            r_blocks_found <= '0;
            r_order_cnt    <= '0;
            r_i            <= '0;
            r_sp           <= '0;
            r_fp           <= '0;
            r_ord          <= '0;
            r_blk          <= '0;
            r_hit          <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_live         <= n_live;
            r_edge_cnt     <= n_edge_cnt;
            r_prev_src     <= n_prev_src;
            r_sticky       <= n_sticky;
            r_blocks_found <= n_blocks_found;
            r_order_cnt    <= n_order_cnt;
            r_i            <= n_i;
            r_sp           <= n_sp;
            r_fp           <= n_fp;
            r_ord          <= n_ord;
            r_blk          <= n_blk;
            r_hit          <= n_hit;
            r_res_valid    <= n_res_valid;
        end
        r_v       <= n_v;
        r_e       <= n_e;
        r_re      <= n_re;
        r_low     <= n_low;
        r_pos     <= n_pos;
        r_w       <= n_w;
        r_fixprev <= n_fixprev;
        r_x       <= n_x;
        r_res     <= n_res;
    end

    // edge targets, row bounds and the search stores
    scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NW)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW)) u_rend (
        .i_clk(i_clk), .i_we(rend_we), .i_waddr(rend_waddr), .i_wdata(rend_wdata),
        .i_raddr(rend_raddr), .o_rdata(rend_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(ECW)) u_rbeg (
        .i_clk(i_clk), .i_we(rbeg_we), .i_waddr(rbeg_waddr), .i_wdata(rbeg_wdata),
        .i_raddr(node_raddr), .o_rdata(rbeg_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_frame (
        .i_clk(i_clk), .i_we(frm_we), .i_waddr(frm_waddr), .i_wdata(frm_wdata),
        .i_raddr(frm_raddr), .o_rdata(frm_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_comp (
        .i_clk(i_clk), .i_we(comp_we), .i_waddr(comp_waddr), .i_wdata(comp_wdata),
        .i_raddr(comp_raddr), .o_rdata(comp_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_spos (
        .i_clk(i_clk), .i_we(spos_we), .i_waddr(spos_waddr), .i_wdata(spos_wdata),
        .i_raddr(node_raddr), .o_rdata(spos_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(2)) u_flags (
        .i_clk(i_clk), .i_we(flg_we), .i_waddr(flg_waddr), .i_wdata(flg_wdata),
        .i_raddr(node_raddr), .o_rdata(flg_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_omap (
        .i_clk(i_clk), .i_we(omap_we), .i_waddr(omap_waddr), .i_wdata(omap_wdata),
        .i_raddr(omap_raddr), .o_rdata(omap_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_nblk (
        .i_clk(i_clk), .i_we(nblk_we), .i_waddr(nblk_waddr), .i_wdata(nblk_wdata),
        .i_raddr(nblk_raddr), .o_rdata(nblk_rd));
    scc_ram #(.DEPTH(MAX_NODES), .WIDTH(CW)) u_bsz (
        .i_clk(i_clk), .i_we(bsz_we), .i_waddr(bsz_waddr), .i_wdata(bsz_wdata),
        .i_raddr(bsz_raddr), .o_rdata(bsz_rd));

    // a load never leaves the block busy
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode == OP_LOAD) |=> !busy)
        else $error("load left the block busy");

    // a run always holds the command channel off
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode == OP_RUN) |=> busy)
        else $error("run did not raise busy");

    // result words never come back to back
    a_res_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe held for two cycles");

    // stacked and ordered nodes together never exceed the node count
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (32'(r_ord) + 32'(r_sp) <= 32'(r_live)))
        else $error("component stack overran the node count");

    // a live frame always sits on the stack while edges are walked
    a_frame_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_fp != '0 && r_sp != '0))
        else $error("edge walk without a live frame");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the strongly connected component orderer
// ---------------------------------------------------------------------------
// a short table of directed words runs first, walked in a loop. a row either
// writes the node count or sends one command word, and a few rows carry a
// typed-in answer. after it come random jobs: node count, sorted edge list
// with some faulty edges mixed in, a run, then reads. every word taken is
// fed to a local component search, and each result word is checked field by
// field against the oldest expected word
// ---------------------------------------------------------------------------
module tb_top;
    import scc_pkg::*;

    localparam int NODE_CAP = 1024;
    localparam int EDGE_CAP = 4096;
    localparam int IDLE_LIMIT = 100000;

    typedef enum logic [1:0] {ROW_WORD, ROW_COUNT} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in       word;
        logic [10:0] count;
        bit        typed;
        t_out      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_in;
    logic        o_res_valid;
    t_out        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;

    strongly_connected_components_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // local copy of the graph job and of the last ordering
    int unsigned nodes_cfg;
    int unsigned edge_dst [EDGE_CAP];
    int unsigned row_stop [NODE_CAP];
    int unsigned call_v [NODE_CAP];
    int unsigned call_e [NODE_CAP];
    int unsigned comp_stk [NODE_CAP];
    int unsigned low_link [NODE_CAP];
    int unsigned stk_pos [NODE_CAP];
    bit [1:0]    node_flg [NODE_CAP];
    int unsigned order_seq [NODE_CAP];
    int unsigned node_comp [NODE_CAP];
    int unsigned comp_size [NODE_CAP];
    int unsigned edges_held, comp_total, ordered_total, last_src;
    logic [1:0]  load_fault;

    t_out expected_words [$];
    t_row rows [$];
    int   fail_count;
    int   idle_cycles;
    bit   idle_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned live_nodes();
        return (nodes_cfg > NODE_CAP) ? NODE_CAP : nodes_cfg;
    endfunction

    task automatic clear_job();
        for (int k = 0; k < NODE_CAP; k++) begin
            row_stop[k] = 0;
        end
        edges_held = 0;
        last_src = 0;
        load_fault = ST_OK;
    endtask

    // only the first fault of a job is kept
    task automatic note_fault(input logic [1:0] code);
        if (load_fault == ST_OK) begin
            load_fault = code;
        end
    endtask

    task automatic store_edge(input int unsigned f, input int unsigned t);
        if (f >= live_nodes() || t >= live_nodes()) begin
            note_fault(ST_RANGE);
        end else if (f < last_src) begin
            note_fault(ST_ORDER);
        end else if (edges_held >= EDGE_CAP) begin
            note_fault(ST_FULL);
        end else begin
            edge_dst[edges_held] = t;
            edges_held++;
            row_stop[f] = edges_held;
            last_src = f;
        end
    endtask

    // tarjan search with an explicit call stack, components laid out as closed
    task automatic order_components();
        int unsigned n, prv, sp, fp, ord, blk, v, e, w, x, p;
        n = live_nodes();
        prv = 0;
        sp = 0;
        fp = 0;
        ord = 0;
        blk = 0;
        // rows without edges take the end of the row before
        for (int unsigned i = 0; i < n; i++) begin
            if (row_stop[i] < prv) row_stop[i] = prv;
            if (row_stop[i] > edges_held) row_stop[i] = edges_held;
            prv = row_stop[i];
            node_flg[i] = 2'b00;
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (node_flg[i] & FLAG_SEEN) continue;
            comp_stk[sp] = i;
            stk_pos[i] = sp;
            low_link[i] = sp;
            node_flg[i] = FLAG_SEEN | FLAG_ON;
            sp++;
            call_v[fp] = i;
            call_e[fp] = (i == 0) ? 0 : row_stop[i - 1];
            fp++;
            while (fp > 0) begin
                v = call_v[fp - 1];
                e = call_e[fp - 1];
                if (e < row_stop[v]) begin
                    w = edge_dst[e];
                    call_e[fp - 1] = e + 1;
                    // destinations beyond the present node count are passed over
                    if (w >= n) continue;
                    if (node_flg[w] & FLAG_ON) begin
                        if (stk_pos[w] < low_link[v]) low_link[v] = stk_pos[w];
                    end else if (!(node_flg[w] & FLAG_SEEN)) begin
                        comp_stk[sp] = w;
                        stk_pos[w] = sp;
                        low_link[w] = sp;
                        node_flg[w] = FLAG_SEEN | FLAG_ON;
                        sp++;
                        call_v[fp] = w;
                        call_e[fp] = (w == 0) ? 0 : row_stop[w - 1];
                        fp++;
                    end
                    continue;
                end
                fp--;
                if (low_link[v] >= stk_pos[v]) begin
                    comp_size[blk] = sp - stk_pos[v];
                    do begin
                        sp--;
                        x = comp_stk[sp];
                        order_seq[ord] = x;
                        ord++;
                        node_comp[x] = blk;
                        node_flg[x] = node_flg[x] & ~FLAG_ON;
                    end while (x != v && sp > 0);
                    blk++;
                end
                if (fp > 0) begin
                    p = call_v[fp - 1];
                    if (low_link[v] < low_link[p]) low_link[p] = low_link[v];
                end
            end
        end
        comp_total = blk;
        ordered_total = ord;
    endtask

    // works out the answer to one taken word, if it has one
    task automatic predict_word(input t_in w, output bit has, output t_out o);
        int unsigned x, b;
        has = 1'b0;
        o = '0;
        case (w.opcode)
            OP_LOAD: begin
                store_edge(w.from_node, w.to_node);
            end
            OP_RUN: begin
                order_components();
                has = 1'b1;
                o.reply_kind = REPLY_RUN;
                o.block_count = comp_total[10:0];
                o.status = load_fault;
                clear_job();
            end
            OP_READ: begin
                has = 1'b1;
                o.reply_kind = REPLY_READ;
                o.block_count = comp_total[10:0];
                o.status = load_fault;
                if (w.position < ordered_total) begin
                    x = order_seq[w.position] % NODE_CAP;
                    b = node_comp[x] % NODE_CAP;
                    o.ordered_node = x[9:0];
                    o.block_index = b[9:0];
                    o.block_size = comp_size[b][10:0];
                end
            end
            default: begin
            end
        endcase
    endtask

    // sends one word; returns at the edge that takes it
    task automatic send_word(input t_in w, input bit typed, input t_out want);
        bit   taken, has;
        t_out o;
        taken = 1'b0;
        start <= 1'b1;
        i_in <= w;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        predict_word(w, has, o);
        if (has) expected_words.push_back(typed ? want : o);
    endtask

    // random gap before a word, only while idling is switched on
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // sender holds off until every answer is in, then lets the block settle
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [10:0] v);
        bit taken;
        taken = 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        nodes_cfg = v;
    endtask

    function automatic t_in make_word(logic [1:0] op, int unsigned f, int unsigned t,
                                      int unsigned p);
        t_in w;
        w.opcode = op;
        w.from_node = f[9:0];
        w.to_node = t[9:0];
        w.position = p[9:0];
        return w;
    endfunction

    function automatic t_out make_reply(logic kind, int unsigned cnt, logic [1:0] st,
                                        int unsigned nd, int unsigned bi, int unsigned bs);
        t_out o;
        o.reply_kind = kind;
        o.block_count = cnt[10:0];
        o.status = st;
        o.ordered_node = nd[9:0];
        o.block_index = bi[9:0];
        o.block_size = bs[10:0];
        return o;
    endfunction

    task automatic add_word(input logic [1:0] op, input int unsigned f, input int unsigned t,
                            input int unsigned p);
        rows.push_back('{ROW_WORD, make_word(op, f, t, p), 11'd0, 1'b0, t_out'('0)});
    endtask

    task automatic add_checked(input logic [1:0] op, input int unsigned p, input t_out want);
        rows.push_back('{ROW_WORD, make_word(op, 0, 0, p), 11'd0, 1'b1, want});
    endtask

    task automatic add_count(input logic [10:0] v);
        rows.push_back('{ROW_COUNT, t_in'('0), v, 1'b0, t_out'('0)});
    endtask

    // one random job: node count, sorted edges with faults mixed in, run, reads
    task automatic random_job();
        int unsigned n, lim, m, src, f, t, pick;
        t_out none;
        none = '0;
        pick = $urandom_range(0, 19);
        case (pick)
            0: n = 0;
            1: n = 1;
            2: n = 1024;
            3: n = 2047;
            default: n = $urandom_range(2, 48);
        endcase
        write_count(n[10:0]);
        lim = (n > NODE_CAP) ? NODE_CAP : n;
        m = $urandom_range(0, 40);
        src = 0;
        for (int k = 0; k < m; k++) begin
            src += (lim > 64) ? $urandom_range(0, 50) : $urandom_range(0, 2);
            if (lim > 0 && src >= lim) src = lim - 1;
            f = src;
            t = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 1023);
            case ($urandom_range(0, 24))
                0: begin
                    f = $urandom_range(0, 1023);
                    t = $urandom_range(0, 1023);
                end
                1: f = (src > 0) ? $urandom_range(0, src - 1) : src;
                2: begin
                    maybe_idle();
                    send_word(make_word(OP_READ, 0, 0, $urandom_range(0, 1023)), 1'b0, none);
                end
                3: begin
                    maybe_idle();
                    send_word(make_word(OP_NOP, $urandom, $urandom, $urandom), 1'b0, none);
                end
                default: begin
                end
            endcase
            maybe_idle();
            send_word(make_word(OP_LOAD, f, t, $urandom), 1'b0, none);
        end
        maybe_idle();
        send_word(make_word(OP_RUN, $urandom, $urandom, $urandom), 1'b0, none);
        repeat ($urandom_range(3, 8)) begin
            maybe_idle();
            if ($urandom_range(0, 4) == 0) begin
                send_word(make_word(OP_READ, $urandom, $urandom, $urandom_range(0, 1023)),
                          1'b0, none);
            end else begin
                send_word(make_word(OP_READ, $urandom, $urandom,
                                    $urandom_range(0, (lim < 1022) ? lim + 1 : 1023)),
                          1'b0, none);
            end
        end
    endtask

    // result side: every strobe is compared with the oldest expected word
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_res_valid === 1'b1) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected, actual %p", $time, o_res);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_res.reply_kind !== want.reply_kind) begin
                    $display("%0t: reply_kind expected %0d actual %0d",
                             $time, want.reply_kind, o_res.reply_kind);
                    fail_count++;
                end
                if (o_res.block_count !== want.block_count) begin
                    $display("%0t: block_count expected %0d actual %0d",
                             $time, want.block_count, o_res.block_count);
                    fail_count++;
                end
                if (o_res.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_res.status);
                    fail_count++;
                end
                if (o_res.ordered_node !== want.ordered_node) begin
                    $display("%0t: ordered_node expected %0d actual %0d",
                             $time, want.ordered_node, o_res.ordered_node);
                    fail_count++;
                end
                if (o_res.block_index !== want.block_index) begin
                    $display("%0t: block_index expected %0d actual %0d",
                             $time, want.block_index, o_res.block_index);
                    fail_count++;
                end
                if (o_res.block_size !== want.block_size) begin
                    $display("%0t: block_size expected %0d actual %0d",
                             $time, want.block_size, o_res.block_size);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on any channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_res_valid === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_out none;
        none = '0;
        fail_count = 0;
        idle_cycles = 0;
        idle_on = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        nodes_cfg = 1;
        comp_total = 0;
        ordered_total = 0;
        clear_job();

        // directed table
        // node count is one out of reset; nothing ordered yet
        add_checked(OP_READ, 0, make_reply(REPLY_READ, 0, ST_OK, 0, 0, 0));
        add_word(OP_LOAD, 0, 0, 0);
        add_word(OP_LOAD, 0, 1, 0);
        add_word(OP_LOAD, 1023, 1023, 0);
        add_word(OP_NOP, 1023, 1023, 1023);
        add_checked(OP_RUN, 0, make_reply(REPLY_RUN, 1, ST_RANGE, 0, 0, 0));
        add_checked(OP_READ, 0, make_reply(REPLY_READ, 1, ST_OK, 0, 0, 1));
        add_checked(OP_READ, 1023, make_reply(REPLY_READ, 1, ST_OK, 0, 0, 0));
        // widest graph: a two-node cycle, an edge out of order, edges at the ends
        add_count(11'd1024);
        add_word(OP_LOAD, 5, 6, 0);
        add_word(OP_LOAD, 6, 5, 0);
        add_word(OP_LOAD, 3, 7, 0);
        add_word(OP_LOAD, 1023, 0, 0);
        add_word(OP_RUN, 0, 0, 0);
        add_word(OP_READ, 0, 0, 0);
        add_word(OP_READ, 0, 0, 512);
        add_word(OP_READ, 0, 0, 1023);
        // count shrunk between load and run: edges past it are passed over
        add_count(11'd8);
        add_word(OP_LOAD, 0, 7, 0);
        add_word(OP_LOAD, 2, 5, 0);
        add_word(OP_LOAD, 5, 0, 0);
        add_word(OP_LOAD, 7, 2, 0);
        add_count(11'd6);
        add_word(OP_RUN, 0, 0, 0);
        add_word(OP_READ, 0, 0, 3);
        // empty graph
        add_count(11'd0);
        add_checked(OP_RUN, 0, make_reply(REPLY_RUN, 0, ST_OK, 0, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_COUNT) begin
                write_count(rows[k].count);
            end else begin
                send_word(rows[k].word, rows[k].typed, rows[k].want);
            end
        end

        // random jobs, idling switched on and off between jobs
        for (int j = 0; j < 20; j++) begin
            idle_on = ($urandom_range(0, 2) != 0);
            random_job();
        end
        // closing jobs without idling
        idle_on = 1'b0;
        for (int j = 0; j < 4; j++) begin
            random_job();
        end

        wait_drained();
        // run ends with a row sweep of the full node range
        repeat (NODE_CAP + 64) @(posedge i_clk);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/scc_pkg.sv
hw/rtl/scc_ram.sv
hw/rtl/strongly_connected_components_top.sv
dv/tb_top.sv
